// ===== rtl/pta_pkg.sv =====
`timescale 1ns / 1ps

package pta_pkg;

   // Entries in one page table (one per virtual page)
   localparam int ENTRIES_PER_TABLE = 64;
   localparam int ENTRY_IDX_W       = 6;
   localparam int FIELD_W           = 6;
   localparam int FREE_MAP_W        = 64;

   // Classified operation handed from the front to the back
   typedef enum logic [1:0] {
      OP_CREATE     = 2'd0,  // create with a valid process number
      OP_SKIP       = 2'd1,  // create for a process out of range: no change
      OP_LOOKUP     = 2'd2,  // lookup through the process record
      OP_LOOKUP_MAP = 2'd3   // lookup through pointer 0 (free-map area)
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_TABLE = 2'd1,
      ST_NO_DATA  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LK_PTR,
      S_LK_ENT,
      S_ALLOC_TBL,
      S_ALLOC_DATA,
      S_REPLY
   } state_type;

   // One queued item
   typedef struct packed {
      op_type             op;
      logic [FIELD_W-1:0] process;
      logic [FIELD_W-1:0] alloc_count;
      logic [FIELD_W-1:0] virtual_page;
   } item_type;

endpackage

// ===== rtl/pta_ram.sv =====
`timescale 1ns / 1ps

module pta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pta_front.sv =====
`timescale 1ns / 1ps

module pta_front #(
   parameter int NUM_PROCESSES = 64
) (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [5:0]           req_process,
   input  logic [5:0]           req_alloc_count,
   input  logic [5:0]           req_virtual_page,
   input  logic                 q_full,
   output logic                 q_push,
   output pta_pkg::item_type    q_item
);

   localparam int PCW = $clog2(NUM_PROCESSES + 1) + 6;

   logic in_range;

   // Process number check against the configured process count
   assign in_range = PCW'(req_process) < PCW'(NUM_PROCESSES);

   // Classify the request
   always_comb begin
      q_item.process      = req_process;
      q_item.alloc_count  = req_alloc_count;
      q_item.virtual_page = req_virtual_page;
      if (!req_action) begin
         q_item.op = in_range ? pta_pkg::OP_CREATE : pta_pkg::OP_SKIP;
      end else begin
         q_item.op = in_range ? pta_pkg::OP_LOOKUP : pta_pkg::OP_LOOKUP_MAP;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== rtl/pta_queue.sv =====
`timescale 1ns / 1ps

module pta_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pta_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pta_pkg::item_type head_item
);

   // Two-entry queue between front and back
   pta_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = fill_ff == 2'd2;
   assign head_valid = fill_ff != 2'd0;
   assign head_item  = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/pta_back.sv =====
`timescale 1ns / 1ps

module pta_back #(
   parameter int NUM_PAGES     = 64,
   parameter int NUM_PROCESSES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pta_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [5:0]        rsp_table_page,
   output logic [5:0]        rsp_pages_granted,
   output logic [5:0]        rsp_physical_page,
   output logic [63:0]       rsp_free_map
);

   localparam int PGW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CW    = $clog2(NUM_PAGES + 1);
   localparam int PRW   = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int CMPW  = (CW > 7) ? CW : 7;
   localparam int RECW  = PGW + pta_pkg::FIELD_W;
   localparam int ENT_D = NUM_PAGES * pta_pkg::ENTRIES_PER_TABLE;
   localparam int EAW   = PGW + pta_pkg::ENTRY_IDX_W;

   pta_pkg::state_type state_ff, state_in;

   // Pages are never released and always taken lowest first, so the used
   // set is always pages 0 .. next_ff-1.
   logic [CW-1:0]  next_ff, next_in;
   logic [NUM_PROCESSES-1:0] rec_vld_ff, rec_vld_in;

   // Work registers of the item in progress
   pta_pkg::op_type    op_ff, op_in;
   logic [PRW-1:0]     proc_ff, proc_in;
   logic [5:0]         count_ff, count_in;
   logic [5:0]         vp_ff, vp_in;
   logic [PGW-1:0]     tpage_ff, tpage_in;
   logic [5:0]         granted_ff, granted_in;
   logic [5:0]         phys_ff, phys_in;
   pta_pkg::status_type status_ff, status_in;

   // Result register
   logic                rsp_valid_ff;
   pta_pkg::status_type rsp_status_ff;
   logic [5:0]          rsp_table_page_ff, rsp_pages_granted_ff, rsp_physical_page_ff;
   logic [63:0]         rsp_free_map_ff, free_map;

   // RAM ports
   logic            rec_wr, rec_rd, ent_wr, ent_rd;
   logic [PRW-1:0]  rec_rd_addr;
   logic [RECW-1:0] rec_rd_data, rec_wr_data;
   logic [EAW-1:0]  ent_wr_addr, ent_rd_addr;
   logic [PGW-1:0]  ent_rd_data;

   logic            pages_left, alloc_done, out_free, rec_hit;
   logic [PGW-1:0]  rec_ptr;
   logic [5:0]      rec_cnt;

   assign pages_left = next_ff < CW'(NUM_PAGES);
   assign alloc_done = granted_ff == count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rec_ptr    = rec_rd_data[RECW-1:pta_pkg::FIELD_W];
   assign rec_cnt    = rec_rd_data[pta_pkg::FIELD_W-1:0];
   assign rec_hit    = (op_ff == pta_pkg::OP_LOOKUP) && rec_vld_ff[proc_ff];

   // Per-process record: table pointer and number of written entries
   pta_ram #(.WIDTH(RECW), .DEPTH(NUM_PROCESSES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr),
      .wr_addr (proc_ff),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   // Page-table entries, addressed by table page and entry index
   pta_ram #(.WIDTH(PGW), .DEPTH(ENT_D)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr),
      .wr_addr (ent_wr_addr),
      .wr_data (next_ff[PGW-1:0]),
      .rd_en   (ent_rd),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pta_pkg::S_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  pta_pkg::OP_CREATE: state_in = pta_pkg::S_ALLOC_TBL;
                  pta_pkg::OP_SKIP:   state_in = pta_pkg::S_REPLY;
                  default:            state_in = pta_pkg::S_LK_PTR;
               endcase
            end
         end
         pta_pkg::S_LK_PTR: begin
            if (rec_hit && rec_ptr != '0 && vp_ff < rec_cnt) begin
               state_in = pta_pkg::S_LK_ENT;
            end else begin
               state_in = pta_pkg::S_REPLY;
            end
         end
         pta_pkg::S_LK_ENT:    state_in = pta_pkg::S_REPLY;
         pta_pkg::S_ALLOC_TBL: state_in = pages_left ? pta_pkg::S_ALLOC_DATA
                                                     : pta_pkg::S_REPLY;
         pta_pkg::S_ALLOC_DATA: begin
            if (alloc_done || !pages_left) begin
               state_in = pta_pkg::S_REPLY;
            end
         end
         pta_pkg::S_REPLY: begin
            if (out_free) begin
               state_in = pta_pkg::S_IDLE;
            end
         end
         default: state_in = pta_pkg::S_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      q_pop  = 1'b0;
      rec_rd = 1'b0;
      rec_wr = 1'b0;
      ent_rd = 1'b0;
      ent_wr = 1'b0;
      case (state_ff)
         pta_pkg::S_IDLE: begin
            q_pop  = q_valid;
            rec_rd = q_valid && (q_item.op == pta_pkg::OP_LOOKUP);
         end
         pta_pkg::S_LK_PTR: begin
            ent_rd = rec_hit && rec_ptr != '0 && vp_ff < rec_cnt;
         end
         pta_pkg::S_ALLOC_DATA: begin
            rec_wr = alloc_done || !pages_left;
            ent_wr = !alloc_done && pages_left;
         end
         default: begin
         end
      endcase
   end

   assign rec_rd_addr = PRW'(q_item.process);
   assign rec_wr_data = {tpage_ff, granted_ff};
   assign ent_wr_addr = {tpage_ff, granted_ff};
   assign ent_rd_addr = {rec_ptr, vp_ff};

   // Datapath
   always_comb begin
      next_in    = next_ff;
      rec_vld_in = rec_vld_ff;
      op_in      = op_ff;
      proc_in    = proc_ff;
      count_in   = count_ff;
      vp_in      = vp_ff;
      tpage_in   = tpage_ff;
      granted_in = granted_ff;
      phys_in    = phys_ff;
      status_in  = status_ff;
      case (state_ff)
         pta_pkg::S_IDLE: begin
            op_in      = q_item.op;
            proc_in    = PRW'(q_item.process);
            count_in   = q_item.alloc_count;
            vp_in      = q_item.virtual_page;
            tpage_in   = '0;
            granted_in = '0;
            phys_in    = '0;
            status_in  = pta_pkg::ST_OK;
         end
         pta_pkg::S_LK_PTR: begin
            tpage_in = rec_hit ? rec_ptr : '0;
            if (!rec_hit || rec_ptr == '0) begin
               // pointer 0 reads the free map: entry i is the used bit of page i
               phys_in = 6'(CMPW'(vp_ff) < CMPW'(next_ff));
            end
         end
         pta_pkg::S_LK_ENT: begin
            phys_in = 6'(ent_rd_data);
         end
         pta_pkg::S_ALLOC_TBL: begin
            if (pages_left) begin
               tpage_in = next_ff[PGW-1:0];
               next_in  = next_ff + 1'b1;
            end else begin
               status_in = pta_pkg::ST_NO_TABLE;
            end
         end
         pta_pkg::S_ALLOC_DATA: begin
            if (alloc_done) begin
               rec_vld_in[proc_ff] = 1'b1;
            end else if (!pages_left) begin
               status_in           = pta_pkg::ST_NO_DATA;
               rec_vld_in[proc_ff] = 1'b1;
            end else begin
               next_in    = next_ff + 1'b1;
               granted_in = granted_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Free map: thermometer of the allocation pointer
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         free_map[i] = CMPW'(i) < CMPW'(next_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pta_pkg::S_IDLE;
         next_ff      <= CW'(1);
         rec_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_ff    <= next_in;
         rec_vld_ff <= rec_vld_in;
         if (state_ff == pta_pkg::S_REPLY && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      proc_ff    <= proc_in;
      count_ff   <= count_in;
      vp_ff      <= vp_in;
      tpage_ff   <= tpage_in;
      granted_ff <= granted_in;
      phys_ff    <= phys_in;
      status_ff  <= status_in;
      if (state_ff == pta_pkg::S_REPLY && out_free) begin
         rsp_status_ff        <= status_ff;
         rsp_table_page_ff    <= 6'(tpage_ff);
         rsp_pages_granted_ff <= granted_ff;
         rsp_physical_page_ff <= phys_ff;
         rsp_free_map_ff      <= free_map;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_table_page    = rsp_table_page_ff;
   assign rsp_pages_granted = rsp_pages_granted_ff;
   assign rsp_physical_page = rsp_physical_page_ff;
   assign rsp_free_map      = rsp_free_map_ff;

   // Entry writes stay inside the requested count
   assert property (@(posedge clock) disable iff (reset)
      ent_wr |-> granted_ff < count_ff && pages_left)
      else $error("entry write beyond requested count");

   // Record write closes the allocation
   assert property (@(posedge clock) disable iff (reset)
      rec_wr |=> state_ff == pta_pkg::S_REPLY)
      else $error("record write not followed by reply");

   // Allocation pointer never moves backward
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> next_ff >= $past(next_ff))
      else $error("allocation pointer moved backward");

endmodule

// ===== rtl/page_table_allocator.sv =====
`timescale 1ns / 1ps

// channel  direction  transfer when               payload
// req      in         req_valid & !req_stall      action, process, alloc_count, virtual_page
// rsp      out        rsp_valid & !rsp_stall      status, table_page, pages_granted,
//                                                 physical_page, free_map
//
// From the request transfer to rsp_valid, a lookup passes the record read, the
// entry read when it reads the table RAM, and the reply; a create takes a table
// page, then the table RAM write port stores one entry per cycle (no data page
// when no table page is left, straight to the reply for an out-of-range process).
// A two-entry queue lets requests transfer while the back end is busy.
// Reset is synchronous; no clearing pass is needed after it.
// rsp_stall holds the result register; the back end waits on it after that.
module page_table_allocator #(
   parameter int NUM_PAGES     = 64,
   parameter int NUM_PROCESSES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [5:0]  req_process,
   input  logic [5:0]  req_alloc_count,
   input  logic [5:0]  req_virtual_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_table_page,
   output logic [5:0]  rsp_pages_granted,
   output logic [5:0]  rsp_physical_page,
   output logic [63:0] rsp_free_map
);

   pta_pkg::item_type push_item, head_item;
   logic q_push, q_full, q_pop, q_valid;

   pta_front #(.NUM_PROCESSES(NUM_PROCESSES)) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_process      (req_process),
      .req_alloc_count  (req_alloc_count),
      .req_virtual_page (req_virtual_page),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   pta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   pta_back #(.NUM_PAGES(NUM_PAGES), .NUM_PROCESSES(NUM_PROCESSES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_table_page    (rsp_table_page),
      .rsp_pages_granted (rsp_pages_granted),
      .rsp_physical_page (rsp_physical_page),
      .rsp_free_map      (rsp_free_map)
   );

endmodule
